// ===== src/sfh_pkg.sv =====
// ----------------------------------------------------------------------------
// sfh_pkg
// Widths and the mixing functions of the 32-bit SuperFastHash byte streamer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfh_pkg;

  localparam int unsigned LEN_W  = 31;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 2;
  localparam int unsigned PEND_W = 24;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [PEND_W-1:0] pend_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam pos_t POS_B0 = 2'd0;
  localparam pos_t POS_B1 = 2'd1;
  localparam pos_t POS_B2 = 2'd2;
  localparam pos_t POS_B3 = 2'd3;

  function automatic hash_t sext8(input logic [BYTE_W-1:0] b);
    return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

  function automatic hash_t mix_group(input hash_t h, input logic [15:0] lo,
                                      input logic [15:0] hi);
    hash_t a;
    hash_t t;
    hash_t m;
    a = h + {16'd0, lo};
    t = ({16'd0, hi} << 11) ^ a;
    m = (a << 16) ^ t;
    return m + (m >> 11);
  endfunction

  function automatic hash_t tail_mix(input hash_t h, input pos_t rem, input pend_t p);
    hash_t a;
    hash_t r;
    a = h;
    r = h;
    unique case (rem)
      POS_B3: begin
        a = h + {16'd0, p[15:0]};
        a = a ^ (a << 16);
        a = a ^ (sext8(p[23:16]) << 18);
        r = a + (a >> 11);
      end
      POS_B2: begin
        a = h + {16'd0, p[15:0]};
        a = a ^ (a << 11);
        r = a + (a >> 17);
      end
      POS_B1: begin
        a = h + sext8(p[7:0]);
        a = a ^ (a << 10);
        r = a + (a >> 1);
      end
      default: r = h;
    endcase
    return r;
  endfunction

  function automatic hash_t aval_first(input hash_t h);
    hash_t a;
    a = h ^ (h << 3);
    return a + (a >> 5);
  endfunction

  function automatic hash_t aval_last(input hash_t h);
    hash_t a;
    a = h ^ (h << 4);
    a = a + (a >> 17);
    a = a ^ (a << 25);
    return a + (a >> 6);
  endfunction

endpackage

`default_nettype wire

// ===== src/superfast_hash_32.sv =====
// ----------------------------------------------------------------------------
// superfast_hash_32
// SuperFastHash (32-bit) over a byte stream, one byte word per clock while byte_stall is low.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle while byte_stall is low, with no gaps needed.
// A word with start_req set opens a message and seeds the hash with
// message_length; its byte is the first message byte. A message's hash passes
// from its last accepted byte through the input register, state-update stage,
// tail stage and result register to hash_value; a start of length 0 yields 0 likewise.
// Bytes past the length, or with no message open, are dropped without result.
// hash_stall fills the four registered stages before byte_stall rises.
`default_nettype none

module superfast_hash_32 (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          byte_valid,
  output logic                         byte_stall,
  input  wire                          start_req,
  input  wire  [sfh_pkg::LEN_W-1:0]    message_length,
  input  wire  [sfh_pkg::BYTE_W-1:0]   byte_value,
  output logic                         hash_valid,
  input  wire                          hash_stall,
  output logic [sfh_pkg::HASH_W-1:0]   hash_value
);
  import sfh_pkg::*;

  logic              in_v;
  logic              in_start;
  logic [LEN_W-1:0]  in_len;
  logic [BYTE_W-1:0] in_byte;

  hash_t             running_hash;
  pend_t             pending_bytes;
  pos_t              group_position;
  logic [LEN_W-1:0]  bytes_remaining;
  logic              message_active;

  logic              f1_v;
  hash_t             f1_hash;
  pos_t              f1_rem;
  pend_t             f1_pend;
  logic              f2_v;
  hash_t             f2_hash;

  logic              ready0;
  logic              ready1;
  logic              ready2;
  logic              ready3;
  logic              take;

  hash_t             h_base;
  pos_t              gp_base;
  pend_t             pend_base;
  logic [LEN_W-1:0]  br_base;
  logic              live;
  logic              zero_len;
  hash_t             h_mix;
  pos_t              gp_mix;
  pend_t             pend_mix;
  logic [LEN_W-1:0]  br_mix;
  logic              last;

  assign ready3     = !hash_valid || !hash_stall;
  assign ready2     = !f2_v || ready3;
  assign ready1     = !f1_v || ready2;
  assign ready0     = !in_v || ready1;
  assign byte_stall = !ready0;
  assign take       = in_v && ready1;

  always_comb begin
    h_base    = running_hash;
    gp_base   = group_position;
    pend_base = pending_bytes;
    br_base   = bytes_remaining;
    live      = message_active && (bytes_remaining != '0);
    zero_len  = 1'b0;
    if (in_start) begin
      h_base    = {1'b0, in_len};
      gp_base   = POS_B0;
      pend_base = '0;
      br_base   = in_len;
      live      = (in_len != '0);
      zero_len  = (in_len == '0);
    end
    h_mix    = h_base;
    pend_mix = pend_base;
    gp_mix   = gp_base + POS_B1;
    unique case (gp_base)
      POS_B0: pend_mix[7:0]   = in_byte;
      POS_B1: pend_mix[15:8]  = in_byte;
      POS_B2: pend_mix[23:16] = in_byte;
      POS_B3: h_mix = mix_group(h_base, pend_base[15:0], {in_byte, pend_base[23:16]});
      default: h_mix = h_base;
    endcase
    br_mix = br_base - {{(LEN_W-1){1'b0}}, 1'b1};
    last   = live && (br_mix == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (ready0) begin
      in_v <= byte_valid;
    end
    if (ready0 && byte_valid) begin
      in_start <= start_req;
      in_len   <= message_length;
      in_byte  <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash    <= '0;
      group_position  <= POS_B0;
      bytes_remaining <= '0;
      message_active  <= 1'b0;
    end else if (take) begin
      if (zero_len) begin
        running_hash    <= '0;
        group_position  <= POS_B0;
        bytes_remaining <= '0;
        message_active  <= 1'b0;
      end else if (live) begin
        running_hash    <= h_mix;
        group_position  <= last ? POS_B0 : gp_mix;
        bytes_remaining <= br_mix;
        message_active  <= !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && live) begin
      pending_bytes <= pend_mix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (ready1) begin
      f1_v <= in_v && (zero_len || last);
    end
    if (ready1) begin
      f1_hash <= zero_len ? '0 : h_mix;
      f1_rem  <= zero_len ? POS_B0 : gp_mix;
      f1_pend <= pend_mix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (ready2) begin
      f2_v <= f1_v;
    end
    if (ready2) begin
      f2_hash <= aval_first(tail_mix(f1_hash, f1_rem, f1_pend));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (ready3) begin
      hash_valid <= f2_v;
    end
    if (ready3) begin
      hash_value <= aval_last(f2_hash);
    end
  end

endmodule

`default_nettype wire

// ===== src/sfh_checker.sv =====
// ----------------------------------------------------------------------------
// sfh_checker
// Port-level checks for the SuperFastHash byte streamer, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        byte_valid,
  input wire                        byte_stall,
  input wire                        hash_valid,
  input wire                        hash_stall,
  input wire [sfh_pkg::HASH_W-1:0]  hash_value
);
  import sfh_pkg::*;

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    hash_valid && hash_stall |=> hash_valid && $stable(hash_value))
    else $error("hash word changed while stalled");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !hash_valid)
    else $error("hash word shown right after reset");

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> hash_valid && hash_stall)
    else $error("byte stall without a stalled hash word");

  a_known_handshake: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({byte_valid, byte_stall, hash_valid}))
    else $error("handshake signal unknown");

endmodule

bind superfast_hash_32 sfh_checker u_sfh_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .hash_valid (hash_valid),
  .hash_stall (hash_stall),
  .hash_value (hash_value)
);

`default_nettype wire
